// ===== rtl/p2f_pkg.sv =====
// Package with the sizes and request codes of the piece-to-file progress tracker.
`default_nettype none
package p2f_pkg;
   localparam int MAX_FILES   = 1024;
   localparam int SIZE_BITS   = 48;
   localparam int MAX_REPORTS = 63;
   localparam int FIDX_W      = $clog2(MAX_FILES);
   localparam int FCNT_W      = $clog2(MAX_FILES + 1);
   localparam int RPT_W       = $clog2(MAX_REPORTS + 1);
   localparam int PLEN_W      = 31;
   localparam int PNUM_W      = 24;
   localparam int OFF_W       = PLEN_W + PNUM_W;
   localparam int FNUM_W      = 10;
   localparam logic [PLEN_W-1:0] PLEN_RESET = PLEN_W'(16384);

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_PIECE = 2'd1,
      REQ_READ  = 2'd2,
      REQ_CLEAR = 2'd3
   } req_code_type;
endpackage
`default_nettype wire

// ===== rtl/piece_to_file_progress_tracker.sv =====
// Top level of the piece-to-file progress tracker: file tables, piece walk and result register.
`default_nettype none
// The tracker holds up to MAX_FILES files laid end to end in on-chip memories
// (size, start offset, pad mark and downloaded bytes) and serves one request at
// a time. A piece-done request finds the file holding the first byte by a
// binary search over the start offsets, one memory read per step, and then each
// overlapped file costs one read, one compute and one write-back step on the
// tables. A waiting result held by rsp_stall delays any request that has a
// further result to give. Every result passes through an output register, so a
// finished result may wait on rsp_stall while the next request is already
// taken. No clearing pass is needed after reset or clear: entries are only used
// below the file count, and a load writes the new file's progress to zero.
module piece_to_file_progress_tracker
   import p2f_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  csr_wr_en,
   input  wire [PLEN_W-1:0]     csr_wr_data,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire [1:0]            req_type,
   input  wire [SIZE_BITS-1:0]  req_file_bytes,
   input  wire                  req_pad_flag,
   input  wire [PNUM_W-1:0]     req_piece_number,
   input  wire                  req_notify,
   input  wire [FNUM_W-1:0]     req_query_file,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic [FNUM_W-1:0]    rsp_file_number,
   output logic [SIZE_BITS-1:0] rsp_progress_bytes,
   output logic                 rsp_completed,
   output logic                 rsp_overflow,
   output logic                 rsp_error,
   output logic                 rsp_last
);
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_LOAD = 4'd1;
   localparam logic [3:0] ST_MUL  = 4'd2;
   localparam logic [3:0] ST_CHK  = 4'd3;
   localparam logic [3:0] ST_BS   = 4'd4;
   localparam logic [3:0] ST_BSC  = 4'd5;
   localparam logic [3:0] ST_WRD  = 4'd6;
   localparam logic [3:0] ST_WCAL = 4'd7;
   localparam logic [3:0] ST_WUPD = 4'd8;
   localparam logic [3:0] ST_FRD  = 4'd9;
   localparam logic [3:0] ST_FOUT = 4'd10;
   localparam logic [3:0] ST_RRD  = 4'd11;
   localparam logic [3:0] ST_ROUT = 4'd12;
   localparam logic [3:0] ST_CLR  = 4'd13;

   // File tables.
   logic [SIZE_BITS-1:0] size_mem  [MAX_FILES];
   logic [SIZE_BITS-1:0] start_mem [MAX_FILES];
   logic                 pad_mem   [MAX_FILES];
   logic [SIZE_BITS-1:0] prog_mem  [MAX_FILES];

   logic [3:0]           state_ff, state_in;
   logic [PLEN_W-1:0]    plen_ff;
   logic [FCNT_W-1:0]    fc_ff, fc_in;
   logic [SIZE_BITS-1:0] total_ff, total_in;

   // Captured request.
   logic [SIZE_BITS-1:0] fbytes_ff;
   logic                 pad_ff;
   logic [PNUM_W-1:0]    pnum_ff;
   logic                 notify_ff;
   logic [FNUM_W-1:0]    query_ff;

   // Piece walk state.
   logic [OFF_W-1:0]     off_ff, off_in;
   logic [FCNT_W-1:0]    lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [FCNT_W-1:0]    idx_ff, idx_in, first_ff, first_in;
   logic [PLEN_W-1:0]    rem_ff, rem_in, add_ff, add_in;
   logic [SIZE_BITS-1:0] pos_ff, pos_in;
   logic [RPT_W-1:0]     k_ff, k_in;
   logic                 over_ff, over_in;

   // Memory read port.
   logic                 rd_en;
   logic [FIDX_W-1:0]    rd_addr;
   logic [SIZE_BITS-1:0] rd_size_ff, rd_start_ff, rd_prog_ff;
   logic                 rd_pad_ff;

   // Memory write controls.
   logic                 ld_we, pg_we;
   logic [FIDX_W-1:0]    wr_addr;
   logic [SIZE_BITS-1:0] pg_wdata;

   // Result register.
   logic                 emit, slot_free;
   logic [FNUM_W-1:0]    e_fnum;
   logic [SIZE_BITS-1:0] e_prog;
   logic                 e_comp, e_ovf, e_err;
   logic                 rsp_last_in;
   logic                 rv_ff;

   // Arithmetic helpers.
   logic [SIZE_BITS:0]   load_sum;
   logic [SIZE_BITS-1:0] span_left, fo, room;
   logic [SIZE_BITS:0]   p_sum;
   logic [SIZE_BITS-1:0] p_sat;
   logic                 p_full;

   assign slot_free = !rv_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rv_ff;

   assign load_sum  = {1'b0, total_ff} + {1'b0, fbytes_ff};
   assign span_left = total_ff - off_ff[SIZE_BITS-1:0];
   assign fo        = pos_ff - rd_start_ff;
   assign room      = (rd_size_ff > fo) ? (rd_size_ff - fo) : '0;
   assign p_sum     = {1'b0, rd_prog_ff} + {{(SIZE_BITS+1-PLEN_W){1'b0}}, add_ff};
   assign p_sat     = (p_sum > {1'b0, rd_size_ff}) ? rd_size_ff : p_sum[SIZE_BITS-1:0];
   assign p_full    = (p_sat >= rd_size_ff);

   always_comb begin
      state_in = state_ff;
      fc_in    = fc_ff;
      total_in = total_ff;
      off_in   = off_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      idx_in   = idx_ff;
      first_in = first_ff;
      rem_in   = rem_ff;
      add_in   = add_ff;
      pos_in   = pos_ff;
      k_in     = k_ff;
      over_in  = over_ff;
      rd_en    = 1'b0;
      rd_addr  = idx_ff[FIDX_W-1:0];
      ld_we    = 1'b0;
      pg_we    = 1'b0;
      wr_addr  = idx_ff[FIDX_W-1:0];
      pg_wdata = p_sat;
      emit     = 1'b0;
      e_fnum   = '0;
      e_prog   = '0;
      e_comp   = 1'b0;
      e_ovf    = 1'b0;
      e_err    = 1'b0;
      rsp_last_in = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_type)
                  REQ_LOAD:  state_in = ST_LOAD;
                  REQ_PIECE: state_in = ST_MUL;
                  REQ_READ:  state_in = ST_RRD;
                  REQ_CLEAR: state_in = ST_CLR;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD: begin
            if (slot_free) begin
               emit   = 1'b1;
               e_fnum = fc_ff[FNUM_W-1:0];
               if (fc_ff >= FCNT_W'(MAX_FILES) || load_sum[SIZE_BITS]) begin
                  e_err = 1'b1;
               end else begin
                  ld_we    = 1'b1;
                  pg_we    = 1'b1;
                  wr_addr  = fc_ff[FIDX_W-1:0];
                  pg_wdata = '0;
                  total_in = load_sum[SIZE_BITS-1:0];
                  fc_in    = fc_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            off_in   = OFF_W'(pnum_ff) * OFF_W'(plen_ff);
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (off_ff >= OFF_W'(total_ff)) begin
               // Piece lies past the end of the data, or the table is empty.
               if (slot_free) begin
                  emit     = 1'b1;
                  e_err    = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               rem_in   = (span_left > SIZE_BITS'(plen_ff)) ? plen_ff
                                                            : span_left[PLEN_W-1:0];
               lo_in    = '0;
               hi_in    = fc_ff;
               k_in     = '0;
               over_in  = 1'b0;
               pos_in   = off_ff[SIZE_BITS-1:0];
               state_in = ST_BS;
            end
         end
         ST_BS: begin
            if (hi_ff - lo_ff > FCNT_W'(1)) begin
               mid_in   = FCNT_W'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
               rd_en    = 1'b1;
               rd_addr  = mid_in[FIDX_W-1:0];
               state_in = ST_BSC;
            end else begin
               first_in = lo_ff;
               idx_in   = lo_ff;
               state_in = ST_WRD;
            end
         end
         ST_BSC: begin
            if (OFF_W'(rd_start_ff) <= off_ff) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff;
            end
            state_in = ST_BS;
         end
         ST_WRD: begin
            if (rem_ff == '0 || idx_ff >= fc_ff) begin
               state_in = ST_FRD;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_WCAL;
            end
         end
         ST_WCAL: begin
            add_in   = (room < SIZE_BITS'(rem_ff)) ? room[PLEN_W-1:0] : rem_ff;
            state_in = ST_WUPD;
         end
         ST_WUPD: begin
            if (p_full && notify_ff && !rd_pad_ff && k_ff < RPT_W'(MAX_REPORTS)) begin
               if (slot_free) begin
                  emit        = 1'b1;
                  e_fnum      = idx_ff[FNUM_W-1:0];
                  e_prog      = p_sat;
                  e_comp      = 1'b1;
                  rsp_last_in = 1'b0;
                  k_in        = k_ff + 1'b1;
                  pg_we       = 1'b1;
                  rem_in      = rem_ff - add_ff;
                  pos_in      = pos_ff + SIZE_BITS'(add_ff);
                  idx_in      = idx_ff + 1'b1;
                  state_in    = ST_WRD;
               end
            end else begin
               if (p_full && notify_ff && !rd_pad_ff) begin
                  over_in = 1'b1;
               end
               pg_we    = 1'b1;
               rem_in   = rem_ff - add_ff;
               pos_in   = pos_ff + SIZE_BITS'(add_ff);
               idx_in   = idx_ff + 1'b1;
               state_in = ST_WRD;
            end
         end
         ST_FRD: begin
            rd_en    = 1'b1;
            rd_addr  = first_ff[FIDX_W-1:0];
            state_in = ST_FOUT;
         end
         ST_FOUT: begin
            if (slot_free) begin
               emit     = 1'b1;
               e_fnum   = first_ff[FNUM_W-1:0];
               e_prog   = rd_prog_ff;
               e_ovf    = over_ff;
               state_in = ST_IDLE;
            end
         end
         ST_RRD: begin
            rd_en    = 1'b1;
            rd_addr  = query_ff;
            state_in = ST_ROUT;
         end
         ST_ROUT: begin
            if (slot_free) begin
               emit   = 1'b1;
               e_fnum = query_ff;
               if (FCNT_W'(query_ff) >= fc_ff) begin
                  e_err = 1'b1;
               end else begin
                  e_prog = rd_prog_ff;
               end
               state_in = ST_IDLE;
            end
         end
         ST_CLR: begin
            if (slot_free) begin
               emit     = 1'b1;
               fc_in    = '0;
               total_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         plen_ff  <= PLEN_RESET;
         fc_ff    <= '0;
         total_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         fc_ff    <= fc_in;
         total_ff <= total_in;
         if (csr_wr_en) begin
            plen_ff <= csr_wr_data;
         end
         if (emit) begin
            rv_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rv_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      off_ff   <= off_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      idx_ff   <= idx_in;
      first_ff <= first_in;
      rem_ff   <= rem_in;
      add_ff   <= add_in;
      pos_ff   <= pos_in;
      k_ff     <= k_in;
      over_ff  <= over_in;
      if (state_ff == ST_IDLE && req_valid) begin
         fbytes_ff <= req_file_bytes;
         pad_ff    <= req_pad_flag;
         pnum_ff   <= req_piece_number;
         notify_ff <= req_notify;
         query_ff  <= req_query_file;
      end
      if (emit) begin
         rsp_file_number    <= e_fnum;
         rsp_progress_bytes <= e_prog;
         rsp_completed      <= e_comp;
         rsp_overflow       <= e_ovf;
         rsp_error          <= e_err;
         rsp_last           <= rsp_last_in;
      end
   end

   // Table memories: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (ld_we) begin
         size_mem[wr_addr]  <= fbytes_ff;
         start_mem[wr_addr] <= total_ff;
         pad_mem[wr_addr]   <= pad_ff;
      end
      if (pg_we) begin
         prog_mem[wr_addr] <= pg_wdata;
      end
      if (rd_en) begin
         rd_size_ff  <= size_mem[rd_addr];
         rd_start_ff <= start_mem[rd_addr];
         rd_pad_ff   <= pad_mem[rd_addr];
         rd_prog_ff  <= prog_mem[rd_addr];
      end
   end

`ifndef SYNTH
   a_fc_bound: assert property (@(posedge clock) disable iff (reset)
      fc_ff <= FCNT_W'(MAX_FILES))
      else $error("file count above table depth");
   a_bs_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BSC) |-> (lo_ff < mid_ff && mid_ff < hi_ff))
      else $error("binary search bounds out of order");
   a_walk_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WCAL) |-> (idx_ff < fc_ff && $past(state_ff) == ST_WRD))
      else $error("walk reads past the file count");
`endif
endmodule
`default_nettype wire
